@@ src/boe_pkg.sv @@
`timescale 1ns / 1ps
package boe_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_THRESH = 2'd0;
  localparam logic [1:0] REG_MINHIT = 2'd1;
  localparam logic [1:0] REG_GAP    = 2'd2;
  localparam logic [1:0] REG_CAL    = 2'd3;

  // configuration reset values
  localparam logic signed [7:0] THRESH_RST = -8'sd65;
  localparam logic [5:0]        MINHIT_RST = 6'd10;
  localparam logic [4:0]        GAP_RST    = 5'd3;
  localparam logic [7:0]        CAL_RST    = 8'd10;

  // output saturation and divide-by-ten reciprocal
  localparam int unsigned       CNT_MAX    = 127;
  localparam int unsigned       PEOPLE_MAX = 2047;
  localparam logic [33:0]       RECIP_10   = 34'd52429;
  localparam int unsigned       RECIP_SH   = 19;
  localparam logic [15:0]       HITS_MAX   = 16'hFFFF;
  localparam logic [15:0]       DROP_MAX   = 16'hFFFF;

  // one table entry
  typedef struct packed {
    logic [47:0] addr;
    logic [15:0] hits;
    logic [31:0] sum;
  } ent_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_R_CHK, ST_R_RD, ST_R_CMP, ST_R_INS,
    ST_A_RD, ST_A_CHK, ST_A_DIV,
    ST_C_INIT, ST_C_RD, ST_C_CMP, ST_C_END,
    ST_M_MUL, ST_M_DIV, ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic ld_in;
    logic idx_clr;
    logic idx_inc;
    logic rd_ent;
    logic wr_hit;
    logic wr_new;
    logic drop_inc;
    logic n_clr;
    logic div_start;
    logic avg_wr;
    logic rd_avg;
    logic clu_clr;
    logic best_clr;
    logic best_upd;
    logic anchor_set;
    logic mul;
    logic recip;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic below;
    logic used_zero;
    logic used_full;
    logic match;
    logic last_ent;
    logic qualifies;
    logic div_done;
    logic n_zero;
    logic last_avg;
    logic found;
    logic out_free;
  } sts_t;

endpackage

@@ src/boe_in_if.sv @@
`timescale 1ns / 1ps
interface boe_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [47:0]       address;
  logic signed [7:0] strength;

  modport source (output valid, kind, address, strength, input ready);
  modport sink (input valid, kind, address, strength, output ready);
endinterface

@@ src/boe_out_if.sv @@
`timescale 1ns / 1ps
interface boe_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] people;
  logic [6:0]  clusters;
  logic [6:0]  qualified;
  logic [15:0] dropped;

  modport source (output valid, people, clusters, qualified, dropped, input ready);
  modport sink (input valid, people, clusters, qualified, dropped, output ready);
endinterface

@@ src/boe_cfg_if.sv @@
`timescale 1ns / 1ps
interface boe_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [7:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

@@ src/boe_div.sv @@
`timescale 1ns / 1ps
module boe_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               neg,
  input  logic [31:0]        mag,
  input  logic [15:0]        divisor,
  output logic               done,
  output logic signed [31:0] quo
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic        done_r;
  logic        neg_r;
  logic [31:0] quo_r;
  logic [15:0] rem_r;
  logic [15:0] div_r;
  logic [16:0] sh;
  logic        ge;
  logic [15:0] rem_nxt;
  logic [31:0] quo_nxt;

  // one restoring step per cycle
  always_comb begin
    sh      = {rem_r, quo_r[31]};
    ge      = sh >= {1'b0, div_r};
    rem_nxt = ge ? 16'(sh - {1'b0, div_r}) : sh[15:0];
    quo_nxt = {quo_r[30:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= neg;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

@@ src/boe_ctrl.sv @@
`timescale 1ns / 1ps
module boe_ctrl
  import boe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in   = 1'b1;
          cmd.idx_clr = 1'b1;
          if (in_kind) begin
            cmd.n_clr = 1'b1;
            state_nxt = sts.used_zero ? ST_C_INIT : ST_A_RD;
          end else begin
            state_nxt = ST_R_CHK;
          end
        end
      end
      // report: search the table
      ST_R_CHK: begin
        if (sts.below) state_nxt = ST_IDLE;
        else if (sts.used_zero) state_nxt = ST_R_INS;
        else state_nxt = ST_R_RD;
      end
      ST_R_RD: begin
        cmd.rd_ent = 1'b1;
        state_nxt  = ST_R_CMP;
      end
      ST_R_CMP: begin
        if (sts.match) begin
          cmd.wr_hit = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (sts.last_ent) begin
          state_nxt = ST_R_INS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_R_RD;
        end
      end
      ST_R_INS: begin
        if (sts.used_full) cmd.drop_inc = 1'b1;
        else cmd.wr_new = 1'b1;
        state_nxt = ST_IDLE;
      end
      // end of scan: averages
      ST_A_RD: begin
        cmd.rd_ent = 1'b1;
        state_nxt  = ST_A_CHK;
      end
      ST_A_CHK: begin
        if (sts.qualifies) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_A_DIV;
        end else if (sts.last_ent) begin
          state_nxt = ST_C_INIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_A_RD;
        end
      end
      ST_A_DIV: begin
        if (sts.div_done) begin
          cmd.avg_wr = 1'b1;
          if (sts.last_ent) begin
            state_nxt = ST_C_INIT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_A_RD;
          end
        end
      end
      // clustering: each pass finds the next anchor
      ST_C_INIT: begin
        cmd.clu_clr  = 1'b1;
        cmd.idx_clr  = 1'b1;
        cmd.best_clr = 1'b1;
        state_nxt    = sts.n_zero ? ST_M_MUL : ST_C_RD;
      end
      ST_C_RD: begin
        cmd.rd_avg = 1'b1;
        state_nxt  = ST_C_CMP;
      end
      ST_C_CMP: begin
        cmd.best_upd = 1'b1;
        if (sts.last_avg) begin
          state_nxt = ST_C_END;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_C_RD;
        end
      end
      ST_C_END: begin
        if (sts.found) begin
          cmd.anchor_set = 1'b1;
          cmd.idx_clr    = 1'b1;
          cmd.best_clr   = 1'b1;
          state_nxt      = ST_C_RD;
        end else begin
          state_nxt = ST_M_MUL;
        end
      end
      // scaling and result
      ST_M_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_M_DIV;
      end
      ST_M_DIV: begin
        cmd.recip = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ src/boe_dp.sv @@
`timescale 1ns / 1ps
module boe_dp
  import boe_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [47:0]        in_address,
  input  logic signed [7:0]  in_strength,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [7:0]         cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [10:0]        out_people,
  output logic [6:0]         out_clusters,
  output logic [6:0]         out_qualified,
  output logic [15:0]        out_dropped
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [7:0]  thr_r;
  logic [5:0]         minh_r;
  logic [4:0]         gap_r;
  logic [7:0]         cal_r;
  logic [47:0]        addr_r;
  logic signed [7:0]  str_r;
  logic [CW-1:0]      used_r;
  logic [15:0]        drop_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      n_r;
  logic [CW-1:0]      clu_r;
  logic signed [31:0] anchor_r;
  logic               have_r;
  logic signed [31:0] best_r;
  logic               found_r;
  logic [16:0]        prod_r;
  logic [10:0]        ppl_r;
  logic               out_valid_r;
  logic [10:0]        people_r;
  logic [6:0]         clusters_r;
  logic [6:0]         qualified_r;
  logic [15:0]        dropped_r;

  ent_t               ent_mem [DEPTH];
  ent_t               ent_q;
  logic signed [31:0] avg_mem [DEPTH];
  logic signed [31:0] avg_q;

  logic [31:0]        str_ext;
  logic               ent_we;
  logic [IW-1:0]      ent_wa;
  ent_t               ent_wd;
  logic               div_done;
  logic signed [31:0] div_q;
  logic [31:0]        sum_mag;
  logic signed [32:0] anchor_gap;
  logic               eligible;
  logic [33:0]        rprod;
  logic [14:0]        rquo;

  assign str_ext = 32'(str_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESH_RST;
      minh_r <= MINHIT_RST;
      gap_r  <= GAP_RST;
      cal_r  <= CAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_THRESH: thr_r  <= cfg_data;
        REG_MINHIT: minh_r <= cfg_data[5:0];
        REG_GAP:    gap_r  <= cfg_data[4:0];
        REG_CAL:    cal_r  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      addr_r <= in_address;
      str_r  <= in_strength;
    end
  end

  // table write port: hit update or new entry
  always_comb begin
    ent_we = cmd.wr_hit | cmd.wr_new;
    ent_wa = cmd.wr_hit ? idx_r[IW-1:0] : used_r[IW-1:0];
    if (cmd.wr_hit) begin
      ent_wd.addr = addr_r;
      ent_wd.hits = (ent_q.hits == HITS_MAX) ? ent_q.hits : ent_q.hits + 16'd1;
      ent_wd.sum  = ent_q.sum + str_ext;
    end else begin
      ent_wd.addr = addr_r;
      ent_wd.hits = 16'd1;
      ent_wd.sum  = str_ext;
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (cmd.rd_ent) ent_q <= ent_mem[idx_r[IW-1:0]];
  end

  // average memory
  always_ff @(posedge clk) begin
    if (cmd.avg_wr) avg_mem[n_r[IW-1:0]] <= div_q;
    if (cmd.rd_avg) avg_q <= avg_mem[idx_r[IW-1:0]];
  end

  // sum over hits, truncated toward zero
  assign sum_mag = ent_q.sum[31] ? 32'(-ent_q.sum) : ent_q.sum;

  boe_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .neg     (ent_q.sum[31]),
    .mag     (sum_mag),
    .divisor (ent_q.hits),
    .done    (div_done),
    .quo     (div_q)
  );

  // table occupancy, drop count, walk index, qualified count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      drop_r <= '0;
      idx_r  <= '0;
      n_r    <= '0;
    end else begin
      if (cmd.emit) begin
        used_r <= '0;
        drop_r <= '0;
      end else begin
        if (cmd.wr_new) used_r <= used_r + CW'(1);
        if (cmd.drop_inc && drop_r != DROP_MAX) drop_r <= drop_r + 16'd1;
      end
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + CW'(1);
      if (cmd.n_clr) n_r <= '0;
      else if (cmd.avg_wr) n_r <= n_r + CW'(1);
    end
  end

  // anchor search: largest value more than the gap below the last anchor
  always_comb begin
    anchor_gap = 33'(anchor_r) - 33'(avg_q);
    eligible   = !have_r || (anchor_gap > $signed({28'd0, gap_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clu_r   <= '0;
      have_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (cmd.clu_clr) begin
        clu_r  <= '0;
        have_r <= 1'b0;
      end else if (cmd.anchor_set) begin
        clu_r  <= clu_r + CW'(1);
        have_r <= 1'b1;
      end
      if (cmd.best_clr) found_r <= 1'b0;
      else if (cmd.best_upd && eligible) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.anchor_set) anchor_r <= best_r;
    if (cmd.best_upd && eligible && (!found_r || avg_q > best_r)) best_r <= avg_q;
  end

  // clusters times calibration, then divide by ten
  assign rprod = 34'(prod_r) * RECIP_10;
  assign rquo  = rprod[33:RECIP_SH];

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= 17'(clu_r) * 17'(cal_r);
    if (cmd.recip) ppl_r <= (32'(rquo) > PEOPLE_MAX) ? 11'(PEOPLE_MAX) : 11'(rquo);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      people_r    <= ppl_r;
      clusters_r  <= (32'(clu_r) > CNT_MAX) ? 7'(CNT_MAX) : 7'(clu_r);
      qualified_r <= (32'(n_r) > CNT_MAX) ? 7'(CNT_MAX) : 7'(n_r);
      dropped_r   <= drop_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_people    = people_r;
  assign out_clusters  = clusters_r;
  assign out_qualified = qualified_r;
  assign out_dropped   = dropped_r;

  // status
  always_comb begin
    sts.below     = str_r < thr_r;
    sts.used_zero = used_r == '0;
    sts.used_full = used_r == CW'(DEPTH);
    sts.match     = ent_q.addr == addr_r;
    sts.last_ent  = (idx_r + CW'(1)) == used_r;
    sts.qualifies = ent_q.hits >= {10'd0, minh_r};
    sts.div_done  = div_done;
    sts.n_zero    = n_r == '0;
    sts.last_avg  = (idx_r + CW'(1)) == n_r;
    sts.found     = found_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule

@@ src/ble_occupancy_estimator_top.sv @@
`timescale 1ns / 1ps
// channel   dir  fields                                     request
// in_ch     in   kind, address[47:0], strength[7:0] signed  report or end of scan
// out_ch    out  people[10:0], clusters, qualified, dropped one per end of scan
// cfg_ch    in   addr[1:0], data[7:0]                       register write, always ready
//
// a report walks the entry memory serially, reading and comparing one entry at a time,
// until an address match or the last used entry; a report below the threshold ends at once
// end of scan: each entry is read and, when it qualifies, averaged by the bit-serial divider,
// then, if any address qualified, clusters+1 passes over the average memory, then scaling
// reset is synchronous active low; table contents need no clearing pass
// a pending result stalls only the final write of the next end of scan
module ble_occupancy_estimator_top
  import boe_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  boe_in_if.sink    in_ch,
  boe_out_if.source out_ch,
  boe_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  boe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  boe_dp #(
    .DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_address    (in_ch.address),
    .in_strength   (in_ch.strength),
    .cfg_we        (cfg_ch.valid),
    .cfg_addr      (cfg_ch.addr),
    .cfg_data      (cfg_ch.data),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_people    (out_ch.people),
    .out_clusters  (out_ch.clusters),
    .out_qualified (out_ch.qualified),
    .out_dropped   (out_ch.dropped)
  );

endmodule

@@ src/boe_chk.sv @@
`timescale 1ns / 1ps
module boe_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] people,
  input logic [6:0]  clusters,
  input logic [6:0]  qualified,
  input logic [15:0] dropped
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(people) && $stable(clusters)
      && $stable(qualified) && $stable(dropped))
    else $error("result changed while stalled");

  // every cluster holds at least one qualified address
  a_clu: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> clusters <= qualified)
    else $error("more clusters than qualified addresses");

  // no clusters means nobody
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clusters == 7'd0 |-> people == 11'd0)
    else $error("people without clusters");

  // reset drops the result
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ble_occupancy_estimator_top boe_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .people    (out_ch.people),
  .clusters  (out_ch.clusters),
  .qualified (out_ch.qualified),
  .dropped   (out_ch.dropped)
);
